/* hdl/page_range_merge_table_assert.svh */
// -----------------------------------------------------------------------------
// Page range merge table assertion macros
// Shared helpers for the concurrent checks in the table controller and datapath.
// Each user module has ports named clock and reset.
// -----------------------------------------------------------------------------
`ifndef PAGE_RANGE_MERGE_TABLE_ASSERT_SVH
`define PAGE_RANGE_MERGE_TABLE_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define PRMT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that, when seen, must be followed in the next cycle by another.
`define PRMT_CHECK_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/prmt_pkg.sv */
// -----------------------------------------------------------------------------
// Page range merge table package
// Result codes, fixed field widths and the command and status bundles that
// join the controller to the datapath.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prmt_pkg;

   // Fixed port field widths.
   localparam int FIELD_W  = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 7;
   localparam int USED_W   = 8;
   localparam int SHIFT_W  = 5;

   // Page shift after reset (4 KiB pages).
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_APPENDED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MERGED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ_UNUSED = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // take the request beat into the working registers
      logic decode;     // latch aligned bounds, start the first table read
      logic reject;     // result is full, invalid or unused index
      logic take_read;  // result is the entry just read
      logic advance;    // step the scan to the next slot
      logic merge;      // widen the current entry and report it
      logic append;     // write a new entry at the end of the table
      logic load_rsp;   // move the finished result to the output register
   } prmt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;    // request reads an entry
      logic read_hit;   // read index is below the entry count
      logic full;       // no free slot left
      logic bad;        // range is invalid after checks
      logic empty;      // table holds no entries
      logic match;      // current scanned entry overlaps or touches the range
      logic last;       // current scanned entry is the last in use
      logic rsp_free;   // output register can take a result this cycle
   } prmt_sts_type;

endpackage

`default_nettype wire

/* hdl/prmt_datapath.sv */
// -----------------------------------------------------------------------------
// Page range merge table datapath
// Holds the page shift register, the range table memory, the entry count,
// the scan pointer, the bound checks and the result and output registers.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_range_merge_table_assert.svh"

module prmt_datapath
   import prmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 128,
   parameter int ADDR_WIDTH  = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration
   input  wire logic                csr_valid,
   input  wire logic [SHIFT_W-1:0]  csr_page_shift,
   // Request payload
   input  wire logic                req_type,
   input  wire logic [FIELD_W-1:0]  req_range_start,
   input  wire logic [FIELD_W-1:0]  req_range_end,
   input  wire logic [SLOT_W-1:0]   req_entry_index,
   // Response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [FIELD_W-1:0]       rsp_entry_start,
   output logic [FIELD_W-1:0]       rsp_entry_end,
   output logic [USED_W-1:0]        rsp_used_count,
   // Controller link
   input  wire prmt_cmd_type        cmd,
   output prmt_sts_type             sts
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int SW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 1;
   localparam int MW = 2 * ADDR_WIDTH;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [SW-1:0] AMASK_S = {{(SW - ADDR_WIDTH){1'b0}}, {ADDR_WIDTH{1'b1}}};

   // Configuration and working registers.
   logic [SHIFT_W-1:0]    page_shift_ff;
   logic                  req_type_ff;
   logic [ADDR_WIDTH-1:0] req_start_ff;
   logic [ADDR_WIDTH-1:0] req_end_ff;
   logic [SLOT_W-1:0]     req_index_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [IW-1:0]         scan_ff;
   logic [ADDR_WIDTH-1:0] new_start_ff;
   logic [ADDR_WIDTH-1:0] new_end_ff;

   // Table memory: start in the upper half of a word, end in the lower half.
   logic [MW-1:0]         table_mem [TABLE_DEPTH];
   logic [MW-1:0]         rd_data_ff;
   logic [IW-1:0]         rd_addr;
   logic                  rd_en;
   logic [IW-1:0]         wr_addr;
   logic [MW-1:0]         wr_data;
   logic                  wr_en;

   // Result registers and output register.
   logic [STATUS_W-1:0]   res_status_ff;
   logic [SLOT_W-1:0]     res_slot_ff;
   logic [ADDR_WIDTH-1:0] res_start_ff;
   logic [ADDR_WIDTH-1:0] res_end_ff;
   logic [CW-1:0]         res_used_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [FIELD_W-1:0]    rsp_start_ff;
   logic [FIELD_W-1:0]    rsp_end_ff;
   logic [USED_W-1:0]     rsp_used_ff;

   // Decode signals.
   logic [31:0]           pmask;
   logic [ADDR_WIDTH-1:0] pmask_a;
   logic [SW-1:0]         end_sum;
   logic                  bad;
   logic                  full;
   logic [XW-1:0]         idx_x;
   logic                  read_hit;
   logic [ADDR_WIDTH-1:0] aligned_start;
   logic [ADDR_WIDTH-1:0] aligned_end;

   // Scan signals.
   logic [ADDR_WIDTH-1:0] cur_start;
   logic [ADDR_WIDTH-1:0] cur_end;
   logic                  cs_lt;
   logic                  ce_lt;
   logic                  cs_gt;
   logic                  ce_gt;
   logic                  match;
   logic [ADDR_WIDTH-1:0] mg_start;
   logic [ADDR_WIDTH-1:0] mg_end;

   // Page shift register; writes are taken on every valid beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= SHIFT_RESET;
      end else if (csr_valid) begin
         page_shift_ff <= csr_page_shift;
      end
   end

   // Capture the request beat, keeping only the address bits in use.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff  <= req_type;
         req_start_ff <= req_range_start[ADDR_WIDTH-1:0];
         req_end_ff   <= req_range_end[ADDR_WIDTH-1:0];
         req_index_ff <= req_entry_index;
      end
   end

   // Bound checks and page rounding on the captured range.
   always_comb begin
      pmask         = (32'd1 << page_shift_ff) - 32'd1;
      pmask_a       = ADDR_WIDTH'(pmask);
      end_sum       = SW'(req_end_ff) + SW'(pmask);
      bad           = (req_start_ff >= req_end_ff) || (req_start_ff == '0) ||
                      (req_end_ff == '0) || (end_sum > AMASK_S);
      full          = (count_ff >= DEPTH_C);
      idx_x         = XW'(req_index_ff);
      read_hit      = (idx_x < XW'(count_ff));
      aligned_start = req_start_ff & ~pmask_a;
      aligned_end   = end_sum[ADDR_WIDTH-1:0] & ~pmask_a;
   end

   // Latch the aligned range and clear the scan pointer, or step the pointer on advance.
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         new_start_ff <= aligned_start;
         new_end_ff   <= aligned_end;
         scan_ff      <= '0;
      end else if (cmd.advance) begin
         scan_ff      <= scan_ff + IW'(1);
      end
   end

   // Compare the entry read last cycle against the new range.
   always_comb begin
      cur_start = rd_data_ff[MW-1:ADDR_WIDTH];
      cur_end   = rd_data_ff[ADDR_WIDTH-1:0];
      cs_lt     = (cur_start < new_start_ff);
      ce_lt     = (cur_end < new_start_ff);
      cs_gt     = (cur_start > new_end_ff);
      ce_gt     = (cur_end > new_end_ff);
      match     = !((cs_lt && ce_lt) || (cs_gt && ce_gt));
      mg_start  = cs_lt ? cur_start : new_start_ff;
      mg_end    = ce_gt ? cur_end : new_end_ff;
   end

   // Memory port selection: a read for decode or the next scan slot,
   // a write for a merge or an append.
   always_comb begin
      rd_en   = cmd.decode || cmd.advance;
      rd_addr = cmd.decode ? (req_type_ff ? idx_x[IW-1:0] : '0) : (scan_ff + IW'(1));
      wr_en   = cmd.merge || cmd.append;
      wr_addr = cmd.merge ? scan_ff : count_ff[IW-1:0];
      wr_data = cmd.merge ? {mg_start, mg_end} : {new_start_ff, new_end_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Entry count.
   always_comb begin
      count_in = cmd.append ? (count_ff + CW'(1)) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         res_status_ff <= req_type_ff ? ST_READ_UNUSED : (full ? ST_FULL : ST_INVALID);
         res_slot_ff   <= req_type_ff ? req_index_ff : '0;
         res_start_ff  <= '0;
         res_end_ff    <= '0;
         res_used_ff   <= count_ff;
      end else if (cmd.take_read) begin
         res_status_ff <= ST_READ_OK;
         res_slot_ff   <= req_index_ff;
         res_start_ff  <= cur_start;
         res_end_ff    <= cur_end;
         res_used_ff   <= count_ff;
      end else if (cmd.merge) begin
         res_status_ff <= ST_MERGED;
         res_slot_ff   <= SLOT_W'(scan_ff);
         res_start_ff  <= mg_start;
         res_end_ff    <= mg_end;
         res_used_ff   <= count_ff;
      end else if (cmd.append) begin
         res_status_ff <= ST_APPENDED;
         res_slot_ff   <= SLOT_W'(count_ff);
         res_start_ff  <= new_start_ff;
         res_end_ff    <= new_end_ff;
         res_used_ff   <= count_in;
      end
   end

   // Output register: a finished result waits here until its beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_start_ff  <= FIELD_W'(res_start_ff);
         rsp_end_ff    <= FIELD_W'(res_end_ff);
         rsp_used_ff   <= USED_W'(res_used_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_start = rsp_start_ff;
   assign rsp_entry_end   = rsp_end_ff;
   assign rsp_used_count  = rsp_used_ff;

   // Status back to the controller.
   always_comb begin
      sts.is_read  = req_type_ff;
      sts.read_hit = read_hit;
      sts.full     = full;
      sts.bad      = bad;
      sts.empty    = (count_ff == '0);
      sts.match    = match;
      sts.last     = ((CW'(scan_ff) + CW'(1)) == count_ff);
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // The count never runs past the table depth.
   `PRMT_CHECK(a_count_bound, count_ff <= DEPTH_C, "entry count exceeds table depth")
   // An append is only issued while a slot is free.
   `PRMT_CHECK(a_append_room, cmd.append |-> (count_ff < DEPTH_C), "append into a full table")
   // A waiting result is never overwritten.
   `PRMT_CHECK(a_no_overwrite, cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready), "result lost")

endmodule

`default_nettype wire

/* hdl/prmt_controller.sv */
// -----------------------------------------------------------------------------
// Page range merge table controller
// Sequences one request at a time: capture, decode, optional scan or read,
// optional table update, then hand-off of the result to the output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_range_merge_table_assert.svh"

module prmt_controller
   import prmt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire prmt_sts_type  sts,
   output prmt_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_SCAN,
      ST_APPEND,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   // Commands follow directly from the state and the datapath status.
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.decode    = (state_ff == ST_DECODE);
      cmd.reject    = (state_ff == ST_DECODE) &&
                      (sts.is_read ? !sts.read_hit : (sts.full || sts.bad));
      cmd.take_read = (state_ff == ST_READ_WAIT);
      cmd.advance   = (state_ff == ST_SCAN) && !sts.match;
      cmd.merge     = (state_ff == ST_SCAN) && sts.match;
      cmd.append    = (state_ff == ST_APPEND);
      cmd.load_rsp  = (state_ff == ST_RESP) && sts.rsp_free;
   end

   // State register and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_DECODE;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_DECODE: begin
               if (sts.is_read) begin
                  state_ff <= sts.read_hit ? ST_READ_WAIT : ST_RESP;
               end else if (sts.full || sts.bad) begin
                  state_ff <= ST_RESP;
               end else if (sts.empty) begin
                  state_ff <= ST_APPEND;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_READ_WAIT: begin
               state_ff <= ST_RESP;
            end
            ST_SCAN: begin
               if (sts.match) begin
                  state_ff <= ST_RESP;
               end else if (sts.last) begin
                  state_ff <= ST_APPEND;
               end
            end
            ST_APPEND: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (sts.rsp_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;

   // Beats are only taken while nothing is in progress.
   `PRMT_CHECK(a_accept_idle, (req_valid && req_ready) |-> (state_ff == ST_IDLE), "beat taken while busy")
   // A valid record into a non-empty table always goes to the scan.
   `PRMT_CHECK_NEXT(a_scan_entry, cmd.decode && !sts.is_read && !sts.full && !sts.bad && !sts.empty, state_ff == ST_SCAN, "scan skipped")
   // The scan is never active on an empty table.
   `PRMT_CHECK(a_scan_nonempty, (state_ff == ST_SCAN) |-> !sts.empty, "scan of empty table")

endmodule

`default_nettype wire

/* hdl/page_range_merge_table.sv */
// -----------------------------------------------------------------------------
// Page range merge table
// Keeps a table of page-aligned address ranges. A record request merges the
// range into the first overlapping or touching entry, or appends it; a read
// request returns one entry by index.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_type, req_range_start,
//                                              req_range_end, req_entry_index
//   rsp      out        rsp_valid/rsp_ready    rsp_status, rsp_slot,
//                                              rsp_entry_start, rsp_entry_end,
//                                              rsp_used_count
//   csr      in         csr_valid/csr_ready    csr_page_shift
//
// After accept, a read that hits passes decode and a table read; a rejected
// request passes decode only; an accepted record passes decode, a scan of
// the entries in use if any, and an append when no entry matches. The scan
// compares one entry per cycle. Reset empties the table and sets 4 KiB pages.
// A result that is not taken waits in the output register; the next request
// is accepted meanwhile and stalls only when its own result is ready.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_range_merge_table
   import prmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 128,
   parameter int ADDR_WIDTH  = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [SHIFT_W-1:0]  csr_page_shift,
   // Request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_type,
   input  wire logic [FIELD_W-1:0]  req_range_start,
   input  wire logic [FIELD_W-1:0]  req_range_end,
   input  wire logic [SLOT_W-1:0]   req_entry_index,
   // Response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [FIELD_W-1:0]       rsp_entry_start,
   output logic [FIELD_W-1:0]       rsp_entry_end,
   output logic [USED_W-1:0]        rsp_used_count
);

   prmt_cmd_type cmd;
   prmt_sts_type sts;

   // The page shift register takes a write on any cycle.
   assign csr_ready = 1'b1;

   // Sequencer.
   prmt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, checks and result registers.
   prmt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_page_shift  (csr_page_shift),
      .req_type        (req_type),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_start (rsp_entry_start),
      .rsp_entry_end   (rsp_entry_end),
      .rsp_used_count  (rsp_used_count),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

`default_nettype wire

/* dv/tb.sv */
// -----------------------------------------------------------------------------
// Page range merge table testbench
// Drives record and read requests through the request channel and checks each
// result against a cycle-free predictor of the range table. It opens with
// hand-picked ranges, then sends random ones grouped per address lane, so that
// merges, appends and a full table are all reached. The page shift is changed
// between phases, and both channels idle and stall at random.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import prmt_pkg::*;
();

   localparam int TABLE_DEPTH      = 128;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 317;
   localparam int STALL_AT         = 200;
   localparam int STALL_CYCLES     = 400;
   localparam longint RUN_LIMIT_NS = 64'd40_000_000;

   // Request kinds as carried on req_type.
   localparam bit OP_RECORD = 1'b0;
   localparam bit OP_READ   = 1'b1;

   typedef struct {
      bit                  kind;
      logic [FIELD_W-1:0]  lo;
      logic [FIELD_W-1:0]  hi;
      logic [SLOT_W-1:0]   index;
   } range_op_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [FIELD_W-1:0]  lo;
      logic [FIELD_W-1:0]  hi;
      logic [USED_W-1:0]   used;
   } range_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SHIFT_W-1:0]  csr_page_shift = SHIFT_RESET;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = OP_RECORD;
   logic [FIELD_W-1:0]  req_range_start = '0;
   logic [FIELD_W-1:0]  req_range_end = '0;
   logic [SLOT_W-1:0]   req_entry_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [FIELD_W-1:0]  rsp_entry_start;
   logic [FIELD_W-1:0]  rsp_entry_end;
   logic [USED_W-1:0]   rsp_used_count;

   // Predictor state: the table as it should stand after every accepted beat.
   logic [FIELD_W-1:0]  held_start [TABLE_DEPTH];
   logic [FIELD_W-1:0]  held_end [TABLE_DEPTH];
   int unsigned         slots_used = 0;
   logic [SHIFT_W-1:0]  model_shift = SHIFT_RESET;

   range_op_type        range_ops_pending [$];
   range_reply_type     replies_due [$];
   range_op_type        bus_op;
   int unsigned         ops_accepted = 0;
   int unsigned         fault_count = 0;
   int unsigned         sender_gap_pct = 0;
   int unsigned         sink_gap_pct = 0;
   int unsigned         stall_left = 0;
   bit                  stall_done = 1'b0;

   // Address lanes used by the random ranges; one first range per lane.
   logic [FIELD_W-1:0]  lane_lo [$];
   logic [FIELD_W-1:0]  lane_hi [$];

   page_range_merge_table dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_page_shift  (csr_page_shift),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_start (rsp_entry_start),
      .rsp_entry_end   (rsp_entry_end),
      .rsp_used_count  (rsp_used_count)
   );

   always #10 clock = ~clock;

   // Works out the result of one request and updates the predicted table.
   function automatic range_reply_type apply_range_op(range_op_type op);
      range_reply_type    r;
      logic [FIELD_W-1:0] page_mask;
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
      int                 hit;
      r = '{default: '0};
      page_mask = (64'd1 << model_shift) - 64'd1;
      hit = -1;
      if (op.kind == OP_READ) begin
         r.slot = op.index;
         if (op.index < slots_used) begin
            r.status = ST_READ_OK;
            r.lo = held_start[op.index];
            r.hi = held_end[op.index];
         end else begin
            r.status = ST_READ_UNUSED;
         end
      end else if (slots_used >= TABLE_DEPTH) begin
         r.status = ST_FULL;
      end else if (op.lo >= op.hi || op.lo == '0 || op.hi == '0 || op.hi > ~page_mask) begin
         r.status = ST_INVALID;
      end else begin
         lo = op.lo & ~page_mask;
         hi = (op.hi + page_mask) & ~page_mask;
         // The first entry that overlaps or touches takes the union.
         for (int i = 0; i < slots_used; i++) begin
            if (hit < 0 && !((held_start[i] < lo && held_end[i] < lo) ||
                             (held_start[i] > hi && held_end[i] > hi)))
               hit = i;
         end
         if (hit >= 0) begin
            if (held_start[hit] > lo) held_start[hit] = lo;
            if (held_end[hit] < hi) held_end[hit] = hi;
            r.status = ST_MERGED;
            r.slot = SLOT_W'(hit);
            r.lo = held_start[hit];
            r.hi = held_end[hit];
         end else begin
            held_start[slots_used] = lo;
            held_end[slots_used] = hi;
            r.status = ST_APPENDED;
            r.slot = SLOT_W'(slots_used);
            r.lo = lo;
            r.hi = hi;
            slots_used++;
         end
      end
      r.used = USED_W'(slots_used);
      return r;
   endfunction

   function automatic range_op_type record_op(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
      range_op_type op;
      op.kind = OP_RECORD;
      op.lo = lo;
      op.hi = hi;
      op.index = SLOT_W'($urandom);
      return op;
   endfunction

   function automatic range_op_type read_op(logic [SLOT_W-1:0] index);
      range_op_type op;
      op.kind = OP_READ;
      op.lo = {$urandom, $urandom};
      op.hi = {$urandom, $urandom};
      op.index = index;
      return op;
   endfunction

   // Request driver: predicts each accepted beat, then offers the next one.
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            replies_due.push_back(apply_range_op(bus_op));
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (range_ops_pending.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
               bus_op = range_ops_pending.pop_front();
               req_valid <= 1'b1;
               req_type <= bus_op.kind;
               req_range_start <= bus_op.lo;
               req_range_end <= bus_op.hi;
               req_entry_index <= bus_op.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result sink: random back-pressure, plus one long hold-off to fill the block.
   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && ops_accepted >= STALL_AT) begin
         rsp_ready <= 1'b0;
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_gap_pct);
      end
   end

   // Result monitor: each accepted beat is held against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      range_reply_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("result beat with no request outstanding: status %0d slot %0d",
                   rsp_status, rsp_slot);
            fault_count++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_status !== due.status) begin
               $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
               fault_count++;
            end
            if (rsp_slot !== due.slot) begin
               $error("rsp_slot: expected %0d, actual %0d", due.slot, rsp_slot);
               fault_count++;
            end
            if (rsp_entry_start !== due.lo) begin
               $error("rsp_entry_start: expected %h, actual %h", due.lo, rsp_entry_start);
               fault_count++;
            end
            if (rsp_entry_end !== due.hi) begin
               $error("rsp_entry_end: expected %h, actual %h", due.hi, rsp_entry_end);
               fault_count++;
            end
            if (rsp_used_count !== due.used) begin
               $error("rsp_used_count: expected %0d, actual %0d", due.used, rsp_used_count);
               fault_count++;
            end
         end
      end
   end

   // Phase sequencer: page shift, idling mode and request mix for each phase.
   initial begin : stimulus
      logic [SHIFT_W-1:0] shift;
      logic [FIELD_W-1:0] page_mask;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] base;
      range_op_type       op;
      int unsigned        pick;
      int unsigned        lane;
      int unsigned        read_span;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: shift = 5'd12;
            1: shift = 5'd21;
            2: shift = 5'd0;
            3: shift = 5'd31;
            4: shift = 5'd16;
            default: shift = 5'd13;
         endcase
         case (phase / 2)
            0: begin
               sender_gap_pct = 26;
               sink_gap_pct = 72;
            end
            1: begin
               sender_gap_pct = 72;
               sink_gap_pct = 26;
            end
            default: begin
               sender_gap_pct = 0;
               sink_gap_pct = 0;
            end
         endcase

         // The block is idle here, so the page shift can be rewritten.
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_page_shift <= shift;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         model_shift = shift;
         page_mask = (64'd1 << shift) - 64'd1;

         // Hand-picked cases, run with 4 KiB pages on an empty table.
         if (phase == 0) begin
            range_ops_pending.push_back(read_op(7'd0));
            range_ops_pending.push_back(record_op(64'h0, 64'h1000));
            range_ops_pending.push_back(record_op(64'h5000, 64'h0));
            range_ops_pending.push_back(record_op(64'h3000, 64'h3000));
            range_ops_pending.push_back(record_op(64'h9000, 64'h1000));
            range_ops_pending.push_back(record_op(64'h1, ~64'h0));
            range_ops_pending.push_back(record_op(64'hFFFF_FFFF_FFFF_E001,
                                                  64'hFFFF_FFFF_FFFF_F000));
            range_ops_pending.push_back(record_op(64'hFFFF_FFFF_FFFF_E001,
                                                  64'hFFFF_FFFF_FFFF_F001));
            range_ops_pending.push_back(record_op(64'h1234, 64'h2001));
            // Touching at the end, then a gap of one page.
            range_ops_pending.push_back(record_op(64'h3000, 64'h4000));
            range_ops_pending.push_back(record_op(64'h5001, 64'h6000));
            // Bridges two entries: only the first one widens.
            range_ops_pending.push_back(record_op(64'h0FFF, 64'h5000));
            range_ops_pending.push_back(record_op(64'h5800, 64'h5900));
            range_ops_pending.push_back(record_op(64'h5100, 64'h5200));
            range_ops_pending.push_back(record_op(64'h1, 64'h2));
            range_ops_pending.push_back(read_op(7'd0));
            range_ops_pending.push_back(read_op(7'd1));
            range_ops_pending.push_back(read_op(7'd2));
            range_ops_pending.push_back(read_op(7'd3));
            range_ops_pending.push_back(read_op(7'd127));
         end

         // Random mix: reads, malformed ranges, new lanes and ranges near a lane.
         repeat (RANDOM_PER_PHASE) begin
            op = read_op(SLOT_W'($urandom));
            pick = $urandom_range(99);
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            if (pick < 30) begin
               read_span = (lane_lo.size() + 4 > TABLE_DEPTH - 1) ?
                           TABLE_DEPTH - 1 : lane_lo.size() + 4;
               if ($urandom_range(9) < 7)
                  op.index = SLOT_W'($urandom_range(0, read_span));
            end else if (pick < 40) begin
               case ($urandom_range(4))
                  0: op = record_op(a > b ? a : b, a > b ? b : a);
                  1: op = record_op(a, a);
                  2: op = record_op('0, b | 64'd1);
                  3: op = record_op(a | 64'd1, '0);
                  default: begin
                     // Rounding the end up would wrap past the top of the space.
                     if (page_mask != '0)
                        op = record_op((a >> 1) | 64'd1, ~64'd0 - (b % page_mask));
                     else
                        op = record_op(a, a);
                  end
               endcase
            end else if (pick < 46 || lane_lo.size() == 0) begin
               // Lane bases lie at least 2^40 apart, so a new lane appends unless the table is full.
               base = {24'((lane_lo.size() + 1) * 24'h9E3779), 40'd0};
               a = base + ((a & 64'h0000_007F_FFFF_FFFF) | (64'd1 << 32));
               b = a + 64'd1 + 64'($urandom >> $urandom_range(0, 31));
               lane_lo.push_back(a);
               lane_hi.push_back(b);
               op = record_op(a, b);
            end else begin
               lane = $urandom_range(0, lane_lo.size() - 1);
               if ($urandom_range(9) == 0) begin
                  base = lane_lo[lane] & ~64'h00FF_FFFF_FFFF;
                  a = base + ((a & 64'h0000_007F_FFFF_FFFF) | (64'd1 << 32));
               end else if ($urandom_range(1) == 0) begin
                  a = lane_lo[lane] - 64'($urandom);
               end else begin
                  a = lane_lo[lane] + 64'($urandom) % (lane_hi[lane] - lane_lo[lane]);
               end
               b = a + 64'd1 + 64'($urandom >> $urandom_range(0, 31));
               op = record_op(a, b);
            end
            range_ops_pending.push_back(op);
         end

         // Drain: every beat sent and every result returned.
         do @(negedge clock);
         while (range_ops_pending.size() != 0 || req_valid || replies_due.size() != 0);
      end

      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (fault_count == 0)
         $display("page_range_merge_table verification clean");
      else
         $display("page_range_merge_table verification failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("page_range_merge_table verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/prmt_pkg.sv
hdl/prmt_datapath.sv
hdl/prmt_controller.sv
hdl/page_range_merge_table.sv
dv/tb.sv
